@@ rtl/nus_pkg.sv @@
// shared types and constants of the nal unit splitter
package nus_pkg;

   localparam int MAX_FRAME_BYTES = 1048576;
   localparam int POS_W = $clog2(MAX_FRAME_BYTES) + 1;
   localparam int OFFSET_W = 20;
   localparam int SIZE_W = 21;
   localparam int TYPE_W = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME_BYTES - 1);
   localparam logic [7:0] START_CODE_LAST = 8'h01;

   localparam logic [TYPE_W-1:0] NAL_SLICE = 5'd1;
   localparam logic [TYPE_W-1:0] NAL_SLICE_IDR = 5'd5;
   localparam logic [TYPE_W-1:0] NAL_SEI = 5'd6;
   localparam logic [TYPE_W-1:0] NAL_AUD = 5'd9;

   localparam logic STATUS_NAL = 1'b0;
   localparam logic STATUS_NONE = 1'b1;

   typedef struct packed {
      logic                status;
      logic [TYPE_W-1:0]   nal_type;
      logic [OFFSET_W-1:0] nal_offset;
      logic [SIZE_W-1:0]   nal_size;
      logic                run_last;
   } nus_result_type;

   // first always holds a result, second only when second_valid is set
   typedef struct packed {
      logic           second_valid;
      nus_result_type first;
      nus_result_type second;
   } nus_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } nus_queue_status_type;

endpackage

@@ rtl/nus_front.sv @@
// byte scanner: start code search, nal bookkeeping and result building
module nus_front import nus_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_frame_end,
   input  logic                 csr_valid,
   input  logic                 csr_drop_sei_aud,
   input  nus_queue_status_type queue_status,
   output logic                 req_ready,
   output logic                 push,
   output nus_entry_type        push_entry
);

   logic [23:0]         window_ff, window_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                pending_ff, pending_in;
   logic                open_ff, open_in;
   logic [OFFSET_W-1:0] open_off_ff, open_off_in;
   logic [TYPE_W-1:0]   open_type_ff, open_type_in;
   logic                slice_ff, slice_in;
   logic                drop_ff;

   logic                accept;
   logic                inframe;
   logic                scan;
   logic                header;
   logic [TYPE_W-1:0]   hdr_type;
   logic [POS_W-1:0]    endpos;
   logic [SIZE_W-1:0]   cur_w, off_w, open_off_w, end_w;
   logic                r0_valid, r1_valid;
   nus_result_type      r0, r1;

   function automatic logic dropped(input logic drop, input logic [TYPE_W-1:0] t);
      dropped = drop && (t == NAL_SEI || t == NAL_AUD);
   endfunction

   assign req_ready = !queue_status.full;
   assign accept = req_valid && req_ready;

   always_comb begin
      inframe = pos_ff < POS_LIMIT;
      scan = inframe && !slice_ff;
      header = scan && pending_ff;
      hdr_type = req_data_byte[TYPE_W-1:0];
      cur_w = SIZE_W'(pos_ff);
      open_off_w = SIZE_W'(open_off_ff);

      r0 = '0;
      r0.status = STATUS_NAL;
      r0.nal_type = open_type_ff;
      r0.nal_offset = open_off_ff;
      r0.nal_size = cur_w - open_off_w - SIZE_W'(4);
      r0_valid = header && open_ff && !dropped(drop_ff, open_type_ff);

      window_in = window_ff;
      pos_in = pos_ff;
      pending_in = pending_ff;
      open_in = open_ff;
      open_off_in = open_off_ff;
      open_type_in = open_type_ff;
      slice_in = slice_ff;

      if (header) begin
         pending_in = 1'b0;
         open_in = 1'b1;
         open_off_in = pos_ff[OFFSET_W-1:0];
         open_type_in = hdr_type;
         slice_in = (hdr_type == NAL_SLICE) || (hdr_type == NAL_SLICE_IDR);
      end
      if (scan) begin
         if (!slice_in && window_ff == 24'd0 && req_data_byte == START_CODE_LAST) begin
            pending_in = 1'b1;
         end
         window_in = {window_ff[15:0], req_data_byte};
      end

      endpos = inframe ? pos_ff : POS_LAST;
      end_w = SIZE_W'(endpos);
      off_w = SIZE_W'(open_off_in);
      r1 = '0;
      r1.run_last = 1'b1;
      if (open_in) begin
         r1.status = STATUS_NAL;
         r1.nal_type = open_type_in;
         r1.nal_offset = open_off_in;
         r1.nal_size = pending_in ? (end_w - SIZE_W'(3) - off_w)
                                  : (end_w - off_w + SIZE_W'(1));
         r1_valid = req_frame_end && !dropped(drop_ff, open_type_in);
      end else begin
         r1.status = STATUS_NONE;
         r1_valid = req_frame_end;
      end

      if (req_frame_end) begin
         window_in = '0;
         pos_in = '0;
         pending_in = 1'b0;
         open_in = 1'b0;
         open_off_in = '0;
         open_type_in = '0;
         slice_in = 1'b0;
      end else if (inframe) begin
         pos_in = pos_ff + POS_W'(1);
      end

      push = accept && (r0_valid || r1_valid);
      push_entry.first = r0_valid ? r0 : r1;
      push_entry.second = r1;
      push_entry.second_valid = r0_valid && r1_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff <= '0;
         pending_ff <= 1'b0;
         open_ff <= 1'b0;
         open_off_ff <= '0;
         open_type_ff <= '0;
         slice_ff <= 1'b0;
         drop_ff <= 1'b1;
      end else begin
         if (accept) begin
            window_ff <= window_in;
            pos_ff <= pos_in;
            pending_ff <= pending_in;
            open_ff <= open_in;
            open_off_ff <= open_off_in;
            open_type_ff <= open_type_in;
            slice_ff <= slice_in;
         end
         if (csr_valid) begin
            drop_ff <= csr_drop_sei_aud;
         end
      end
   end

endmodule

@@ rtl/nus_queue.sv @@
// short result queue between scanner and output stage
module nus_queue import nus_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  nus_entry_type        push_entry,
   input  logic                 pop,
   output nus_entry_type        head,
   output nus_queue_status_type status
);

   nus_entry_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head = mem_ff[rd_ptr_ff];
   assign status.full = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/nus_back.sv @@
// output stage: splits queue entries into single transactions
module nus_back import nus_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  nus_entry_type        head,
   input  nus_queue_status_type queue_status,
   output logic                 pop,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_status,
   output logic [TYPE_W-1:0]    rsp_nal_type,
   output logic [OFFSET_W-1:0]  rsp_nal_offset,
   output logic [SIZE_W-1:0]    rsp_nal_size,
   output logic                 rsp_run_last
);

   logic           valid_ff, valid_in;
   logic           second_ff, second_in;
   nus_result_type out_ff, out_in;
   logic           load;

   always_comb begin
      load = !valid_ff || rsp_ready;
      valid_in = valid_ff;
      second_in = second_ff;
      out_in = out_ff;
      pop = 1'b0;
      if (load) begin
         valid_in = !queue_status.empty;
         if (!queue_status.empty) begin
            out_in = second_ff ? head.second : head.first;
            pop = second_ff || !head.second_valid;
            second_in = !pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         second_ff <= second_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = out_ff.status;
   assign rsp_nal_type = out_ff.nal_type;
   assign rsp_nal_offset = out_ff.nal_offset;
   assign rsp_nal_size = out_ff.nal_size;
   assign rsp_run_last = out_ff.run_last;

endmodule

@@ rtl/h264_nal_unit_splitter.sv @@
// top level of the annex b nal unit splitter
// a result goes through the queue and then the output register before it is on rsp
// throughput: one byte per cycle; the scanner takes a byte whenever the 4-entry queue has room
// a byte that closes two nals yields two transactions on rsp, one after the other
// reset (synchronous): scan state and queue are cleared, drop_sei_aud returns to 1
module h264_nal_unit_splitter import nus_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_frame_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_status,
   output logic [TYPE_W-1:0]   rsp_nal_type,
   output logic [OFFSET_W-1:0] rsp_nal_offset,
   output logic [SIZE_W-1:0]   rsp_nal_size,
   output logic                rsp_run_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_drop_sei_aud
);

   nus_queue_status_type queue_status;
   nus_entry_type        push_entry, head;
   logic                 push, pop;

   assign csr_ready = 1'b1;

   nus_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_data_byte    (req_data_byte),
      .req_frame_end    (req_frame_end),
      .csr_valid        (csr_valid),
      .csr_drop_sei_aud (csr_drop_sei_aud),
      .queue_status     (queue_status),
      .req_ready        (req_ready),
      .push             (push),
      .push_entry       (push_entry)
   );

   nus_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   nus_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .queue_status   (queue_status),
      .pop            (pop),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_nal_type   (rsp_nal_type),
      .rsp_nal_offset (rsp_nal_offset),
      .rsp_nal_size   (rsp_nal_size),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

@@ rtl/nus_checker.sv @@
// port-level checks for the nal unit splitter
module nus_checker import nus_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_status,
   input logic [TYPE_W-1:0]   rsp_nal_type,
   input logic [OFFSET_W-1:0] rsp_nal_offset,
   input logic [SIZE_W-1:0]   rsp_nal_size,
   input logic                rsp_run_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nal_offset)
         && $stable(rsp_nal_size) && $stable(rsp_status))
      else $error("rsp transaction changed while stalled");

   a_none_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NONE |-> rsp_run_last
         && rsp_nal_type == '0 && rsp_nal_offset == '0 && rsp_nal_size == '0)
      else $error("malformed none-found transaction");

   a_nal_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NAL |->
         (33'(rsp_nal_offset) + 33'(rsp_nal_size)) <= 33'(MAX_FRAME_BYTES))
      else $error("nal extends past frame limit");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind h264_nal_unit_splitter nus_checker u_nus_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_nal_type   (rsp_nal_type),
   .rsp_nal_offset (rsp_nal_offset),
   .rsp_nal_size   (rsp_nal_size),
   .rsp_run_last   (rsp_run_last)
);

@@ tb/sv/tb_h264_nal_unit_splitter.sv @@
// self-checking testbench of the annex b nal unit splitter: directed table, random frames
module tb_h264_nal_unit_splitter;
   import nus_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam time CLOCK_PERIOD = 8ns;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_BYTES = 250;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           frame_end;
      logic           typed;
      nus_result_type result;
   } directed_row_type;

   localparam nus_result_type NO_RESULT = '0;

   // typed rows carry the one result the byte must give, the others go to the predictor
   localparam directed_row_type DIRECTED_ROWS [29] = '{
      '{8'hff, 1'b1, 1'b1, '{STATUS_NONE, 5'd0, 20'd0, 21'd0, 1'b1}},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h7f, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b1, 1'b1, '{STATUS_NAL, 5'd31, 20'd4, 21'd1, 1'b1}},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'he0, 1'b1, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h09, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h65, 1'b1, 1'b0, NO_RESULT}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_data_byte = '0;
   logic                req_frame_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_status;
   logic [TYPE_W-1:0]   rsp_nal_type;
   logic [OFFSET_W-1:0] rsp_nal_offset;
   logic [SIZE_W-1:0]   rsp_nal_size;
   logic                rsp_run_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_drop_sei_aud = 1'b1;

   logic                row_typed = 1'b0;
   nus_result_type      row_result = '0;

   bit send_gaps = 1'b1;
   bit take_gaps = 1'b1;
   bit hold_off_due = 1'b0;
   int mismatch_count = 0;
   int idle_cycles = 0;

   // predictor state, reset values
   bit                  drop_sei_aud_copy = 1'b1;
   logic [23:0]         scan_window = '0;
   int unsigned         scan_position = 0;
   bit                  header_due = 1'b0;
   bit                  nal_is_open = 1'b0;
   int unsigned         open_start = 0;
   logic [TYPE_W-1:0]   open_kind = '0;
   bit                  slice_seen = 1'b0;

   nus_result_type      step_nals[$];
   nus_result_type      awaited_nals[$];

   h264_nal_unit_splitter DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_nal_type     (rsp_nal_type),
      .rsp_nal_offset   (rsp_nal_offset),
      .rsp_nal_size     (rsp_nal_size),
      .rsp_run_last     (rsp_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_drop_sei_aud (csr_drop_sei_aud)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic string nal_text(nus_result_type r);
      return $sformatf("status=%0d type=%0d offset=%0d size=%0d run_last=%0d",
                       r.status, r.nal_type, r.nal_offset, r.nal_size, r.run_last);
   endfunction

   function automatic void report_nal(logic st, logic [TYPE_W-1:0] kind,
                                      int unsigned start, int unsigned size);
      nus_result_type r;
      if (st == STATUS_NAL && drop_sei_aud_copy && (kind == NAL_SEI || kind == NAL_AUD))
         return;
      r.status = st;
      r.nal_type = kind;
      r.nal_offset = OFFSET_W'(start);
      r.nal_size = SIZE_W'(size);
      r.run_last = 1'b0;
      step_nals.push_back(r);
   endfunction

   task automatic scan_byte(input logic [7:0] b, input logic last);
      int unsigned cur;
      int unsigned end_at;
      int unsigned size;
      bit in_frame;
      int count_prior;
      step_nals.delete();
      cur = scan_position;
      in_frame = cur < MAX_FRAME_BYTES;
      if (in_frame && !slice_seen) begin
         if (header_due) begin
            header_due = 1'b0;
            if (nal_is_open)
               report_nal(STATUS_NAL, open_kind, open_start, cur - open_start - 4);
            nal_is_open = 1'b1;
            open_start = cur;
            open_kind = b[TYPE_W-1:0];
            if (open_kind == NAL_SLICE || open_kind == NAL_SLICE_IDR)
               slice_seen = 1'b1;
         end
         if (!slice_seen && scan_window == '0 && b == START_CODE_LAST)
            header_due = 1'b1;
         scan_window = {scan_window[15:0], b};
      end
      if (last) begin
         end_at = in_frame ? cur : MAX_FRAME_BYTES - 1;
         count_prior = step_nals.size();
         if (nal_is_open) begin
            size = header_due ? end_at - 3 - open_start : end_at - open_start + 1;
            report_nal(STATUS_NAL, open_kind, open_start, size);
         end else begin
            report_nal(STATUS_NONE, '0, 0, 0);
         end
         if (step_nals.size() > count_prior)
            step_nals[step_nals.size() - 1].run_last = 1'b1;
         scan_window = '0;
         scan_position = 0;
         header_due = 1'b0;
         nal_is_open = 1'b0;
         open_start = 0;
         open_kind = '0;
         slice_seen = 1'b0;
      end else if (in_frame) begin
         scan_position = cur + 1;
      end
   endtask

   // predictor, scoreboard and watchdog
   always @(posedge clock) begin : monitor
      nus_result_type got;
      nus_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            drop_sei_aud_copy = csr_drop_sei_aud;
         if (req_valid && req_ready) begin
            scan_byte(req_data_byte, req_frame_end);
            if (row_typed)
               awaited_nals.push_back(row_result);
            else
               foreach (step_nals[i]) awaited_nals.push_back(step_nals[i]);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_nal_type, rsp_nal_offset, rsp_nal_size, rsp_run_last};
            if (awaited_nals.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transaction: %s", $time, nal_text(got));
            end else begin
               want = awaited_nals.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: mismatch: expected %s, actual %s", $time,
                           nal_text(want), nal_text(got));
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // result side
   initial begin : receiver
      int gap;
      wait (!reset);
      forever begin
         gap = take_gaps ? $urandom_range(0, 4) : 0;
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            gap = HOLD_OFF_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_item(input logic [7:0] b, input logic last, input logic typed,
                            input nus_result_type result);
      int gap;
      gap = send_gaps ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_frame_end <= last;
      row_typed <= typed;
      row_result <= result;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic finish_phase;
      req_valid <= 1'b0;
      while (awaited_nals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_drop_sei_aud(input logic value);
      csr_valid <= 1'b1;
      csr_drop_sei_aud <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   task automatic push_start_code(ref logic [7:0] frame_bytes[$], input bit shared_zero);
      if (!shared_zero)
         frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(START_CODE_LAST);
   endtask

   task automatic send_random_frame(output int unsigned count);
      logic [7:0] frame_bytes[$];
      logic [7:0] header;
      int unsigned nal_total;
      int unsigned style;
      bit shared_zero;
      shared_zero = 1'b0;
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
      end else begin
         nal_total = $urandom_range(1, 4);
         repeat (nal_total) begin
            push_start_code(frame_bytes, shared_zero);
            header = 8'($urandom);
            style = $urandom_range(0, 7);
            case (style)
               0: header[TYPE_W-1:0] = NAL_SEI;
               1: header[TYPE_W-1:0] = NAL_AUD;
               2: header[TYPE_W-1:0] = $urandom_range(0, 1) ? NAL_SLICE : NAL_SLICE_IDR;
               3: header = 8'h00;
               default: ;
            endcase
            frame_bytes.push_back(header);
            // a zero header may open the next start code
            shared_zero = (style == 3);
            if (!shared_zero)
               repeat ($urandom_range(0, 12)) frame_bytes.push_back(8'($urandom));
         end
         case ($urandom_range(0, 5))
            0: push_start_code(frame_bytes, shared_zero);
            1: begin
               push_start_code(frame_bytes, shared_zero);
               frame_bytes.push_back(8'($urandom));
            end
            default: ;
         endcase
      end
      foreach (frame_bytes[i])
         send_item(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NO_RESULT);
      count = frame_bytes.size();
   endtask

   task automatic random_phase(input int unsigned target);
      int unsigned sent;
      int unsigned count;
      sent = 0;
      while (sent < target) begin
         send_random_frame(count);
         sent += count;
      end
      finish_phase();
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[r])
         send_item(DIRECTED_ROWS[r].data_byte, DIRECTED_ROWS[r].frame_end,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
      finish_phase();

      write_drop_sei_aud(1'b0);
      random_phase(PHASE_BYTES);

      write_drop_sei_aud(1'b1);
      take_gaps = 1'b0;
      random_phase(PHASE_BYTES);

      // receiver stalls while bytes keep coming
      write_drop_sei_aud(1'b0);
      send_gaps = 1'b0;
      hold_off_due = 1'b1;
      random_phase(PHASE_BYTES);

      write_drop_sei_aud(1'b1);
      send_gaps = 1'b1;
      take_gaps = 1'b1;
      random_phase(PHASE_BYTES);

      if (awaited_nals.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d results never arrived", $time, awaited_nals.size());
      end
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ h264_nal_unit_splitter.f @@
rtl/nus_pkg.sv
rtl/nus_front.sv
rtl/nus_queue.sv
rtl/nus_back.sv
rtl/h264_nal_unit_splitter.sv
rtl/nus_checker.sv
tb/sv/tb_h264_nal_unit_splitter.sv
